[rtl/core/tfab_pkg.sv]
// ----------------------------------------------------------------------------
// tfab_pkg: shared types and constants for the TCP FIN+ACK reply builder
// Holds the request record passed from the front end to the back end,
// the configuration register indexes and the fixed reply header words.
// ----------------------------------------------------------------------------
`default_nettype none

package tfab_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int SUM_W      = 21;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_OWN_MAC_EN      = 3'd0;
    localparam t_cfg_idx CFG_OWN_MAC         = 3'd1;
    localparam t_cfg_idx CFG_NEXT_HOP_MAC_EN = 3'd2;
    localparam t_cfg_idx CFG_NEXT_HOP_MAC    = 3'd3;

    localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
    localparam logic [15:0] IP_TOTAL_LEN   = 16'd40;
    localparam logic [15:0] IP_FLAG_DF     = 16'd16384;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [15:0] TCP_HDR_LEN    = 16'd20;
    localparam logic [15:0] TCP_OFF_FLAGS  = 16'h5011;
    localparam logic [15:0] TCP_WINDOW     = 16'd64240;
    localparam logic [31:0] IP_TCP_MIN_HDR = 32'd20;

    typedef struct packed {
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] ip_id;
        logic [7:0]  ttl;
    } t_reply;

    typedef struct packed {
        logic   push;
        t_reply item;
    } t_push;

endpackage

`default_nettype wire

[rtl/core/tcp_fin_ack_reply_builder_core.sv]
// ----------------------------------------------------------------------------
// tcp_fin_ack_reply_builder_core: FIN+ACK teardown reply header builder
// Turns the header fields of one captured IPv4/TCP frame into the header
// fields and both checksums of a FIN+ACK reply toward the sender.
//
//   channel   | handshake              | payload
//   ----------+------------------------+----------------------------------
//   request   | i_start / o_busy       | i_in_*, i_flow_ip_id, i_flow_ttl
//   result    | o_valid strobe         | o_out_*, o_ip_checksum, o_tcp_checksum
//   config    | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// One request per cycle while o_busy is low; the result strobe follows the
// accepting edge through the queue write, checksum sum stage and fold stage.
// The back end drains the queue every cycle; o_busy stays low if QUEUE_DEPTH > 1.
// Reset is synchronous: it clears the configuration, queue and strobes.
// The result is shown for one cycle only; the receiver takes it then.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_fin_ack_reply_builder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    output logic                                 o_busy,
    input  wire logic                            i_cfg_we,
    input  wire tfab_pkg::t_cfg_idx              i_cfg_idx,
    input  wire logic [tfab_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [47:0]                     i_in_src_mac,
    input  wire logic [47:0]                     i_in_dst_mac,
    input  wire logic [31:0]                     i_in_src_ip,
    input  wire logic [31:0]                     i_in_dst_ip,
    input  wire logic [15:0]                     i_in_src_port,
    input  wire logic [15:0]                     i_in_dst_port,
    input  wire logic [31:0]                     i_in_seq,
    input  wire logic [31:0]                     i_in_ack,
    input  wire logic [15:0]                     i_in_ip_total_len,
    input  wire logic [3:0]                      i_in_tcp_data_offset,
    input  wire logic [15:0]                     i_flow_ip_id,
    input  wire logic [7:0]                      i_flow_ttl,
    output logic                                 o_valid,
    output logic [47:0]                          o_out_src_mac,
    output logic [47:0]                          o_out_dst_mac,
    output logic [31:0]                          o_out_src_ip,
    output logic [31:0]                          o_out_dst_ip,
    output logic [15:0]                          o_out_src_port,
    output logic [15:0]                          o_out_dst_port,
    output logic [31:0]                          o_out_seq,
    output logic [31:0]                          o_out_ack,
    output logic [15:0]                          o_out_ip_id,
    output logic [7:0]                           o_out_ttl,
    output logic [15:0]                          o_ip_checksum,
    output logic [15:0]                          o_tcp_checksum
);

    tfab_pkg::t_push  push;
    tfab_pkg::t_reply q_item;
    tfab_pkg::t_reply res_item;
    logic             q_full;
    logic             q_valid;
    logic             accept;

    assign o_busy = q_full;
    assign accept = i_start && !q_full;

    tfab_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_accept             (accept),
        .i_in_src_mac         (i_in_src_mac),
        .i_in_dst_mac         (i_in_dst_mac),
        .i_in_src_ip          (i_in_src_ip),
        .i_in_dst_ip          (i_in_dst_ip),
        .i_in_src_port        (i_in_src_port),
        .i_in_dst_port        (i_in_dst_port),
        .i_in_seq             (i_in_seq),
        .i_in_ack             (i_in_ack),
        .i_in_ip_total_len    (i_in_ip_total_len),
        .i_in_tcp_data_offset (i_in_tcp_data_offset),
        .i_flow_ip_id         (i_flow_ip_id),
        .i_flow_ttl           (i_flow_ttl),
        .o_push               (push)
    );

    tfab_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_valid),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    tfab_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_item         (q_item),
        .o_valid        (o_valid),
        .o_item         (res_item),
        .o_ip_checksum  (o_ip_checksum),
        .o_tcp_checksum (o_tcp_checksum)
    );

    assign o_out_src_mac  = res_item.src_mac;
    assign o_out_dst_mac  = res_item.dst_mac;
    assign o_out_src_ip   = res_item.src_ip;
    assign o_out_dst_ip   = res_item.dst_ip;
    assign o_out_src_port = res_item.src_port;
    assign o_out_dst_port = res_item.dst_port;
    assign o_out_seq      = res_item.seq;
    assign o_out_ack      = res_item.ack;
    assign o_out_ip_id    = res_item.ip_id;
    assign o_out_ttl      = res_item.ttl;

endmodule

`default_nettype wire

[rtl/core/tfab_front.sv]
// ----------------------------------------------------------------------------
// tfab_front: request intake and reply field derivation
// Holds the configuration registers, swaps addresses and ports, picks the
// MACs, and computes the reply ack number and IP id for each request.
// ----------------------------------------------------------------------------
`default_nettype none

module tfab_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire tfab_pkg::t_cfg_idx              i_cfg_idx,
    input  wire logic [tfab_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_accept,
    input  wire logic [47:0]                     i_in_src_mac,
    input  wire logic [47:0]                     i_in_dst_mac,
    input  wire logic [31:0]                     i_in_src_ip,
    input  wire logic [31:0]                     i_in_dst_ip,
    input  wire logic [15:0]                     i_in_src_port,
    input  wire logic [15:0]                     i_in_dst_port,
    input  wire logic [31:0]                     i_in_seq,
    input  wire logic [31:0]                     i_in_ack,
    input  wire logic [15:0]                     i_in_ip_total_len,
    input  wire logic [3:0]                      i_in_tcp_data_offset,
    input  wire logic [15:0]                     i_flow_ip_id,
    input  wire logic [7:0]                      i_flow_ttl,
    output tfab_pkg::t_push                      o_push
);

    logic        r_own_mac_en;
    logic [47:0] r_own_mac;
    logic        r_next_hop_mac_en;
    logic [47:0] r_next_hop_mac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac_en      <= 1'b0;
            r_own_mac         <= '0;
            r_next_hop_mac_en <= 1'b0;
            r_next_hop_mac    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tfab_pkg::CFG_OWN_MAC_EN:      r_own_mac_en      <= i_cfg_data[0];
                tfab_pkg::CFG_OWN_MAC:         r_own_mac         <= i_cfg_data[47:0];
                tfab_pkg::CFG_NEXT_HOP_MAC_EN: r_next_hop_mac_en <= i_cfg_data[0];
                tfab_pkg::CFG_NEXT_HOP_MAC:    r_next_hop_mac    <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_push.push          = i_accept;
        o_push.item.src_mac  = r_own_mac_en ? r_own_mac : i_in_dst_mac;
        o_push.item.dst_mac  = r_next_hop_mac_en ? r_next_hop_mac : i_in_src_mac;
        o_push.item.src_ip   = i_in_dst_ip;
        o_push.item.dst_ip   = i_in_src_ip;
        o_push.item.src_port = i_in_dst_port;
        o_push.item.dst_port = i_in_src_port;
        o_push.item.seq      = i_in_ack;
        o_push.item.ack      = i_in_seq + {16'd0, i_in_ip_total_len}
                               - {26'd0, i_in_tcp_data_offset, 2'b00}
                               - tfab_pkg::IP_TCP_MIN_HDR;
        o_push.item.ip_id    = i_flow_ip_id + 16'd1;
        o_push.item.ttl      = i_flow_ttl;
    end

endmodule

`default_nettype wire

[rtl/core/tfab_queue.sv]
// ----------------------------------------------------------------------------
// tfab_queue: short request queue between front and back ends
// A small FIFO of derived reply records; full marks the block busy.
// ----------------------------------------------------------------------------
`default_nettype none

module tfab_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tfab_pkg::t_push  i_push,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output tfab_pkg::t_reply      o_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    tfab_pkg::t_reply r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

endmodule

`default_nettype wire

[rtl/core/tfab_back.sv]
// ----------------------------------------------------------------------------
// tfab_back: checksum engine and result register
// Sums the reply IP header words and the TCP pseudo-header and header words
// in one stage, then folds, inverts and presents the reply for one cycle in the next.
// ----------------------------------------------------------------------------
`default_nettype none

module tfab_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire tfab_pkg::t_reply  i_item,
    output logic                   o_valid,
    output tfab_pkg::t_reply       o_item,
    output logic [15:0]            o_ip_checksum,
    output logic [15:0]            o_tcp_checksum
);

    localparam int SW = tfab_pkg::SUM_W;

    logic             r_s1_valid;
    tfab_pkg::t_reply r_s1_item;
    logic [SW-1:0]    r_ip_sum;
    logic [SW-1:0]    r_tcp_sum;
    logic [SW-1:0]    n_ip_sum;
    logic [SW-1:0]    n_tcp_sum;
    logic [16:0]      ip_fold1, ip_fold2;
    logic [16:0]      tcp_fold1, tcp_fold2;

    function automatic logic [SW-1:0] ext(input logic [15:0] w);
        ext = {{(SW-16){1'b0}}, w};
    endfunction

    always_comb begin
        n_ip_sum = ext(tfab_pkg::IP_VER_IHL_TOS) + ext(tfab_pkg::IP_TOTAL_LEN)
                 + ext(i_item.ip_id) + ext(tfab_pkg::IP_FLAG_DF)
                 + ext({i_item.ttl, tfab_pkg::PROTO_TCP})
                 + ext(i_item.src_ip[31:16]) + ext(i_item.src_ip[15:0])
                 + ext(i_item.dst_ip[31:16]) + ext(i_item.dst_ip[15:0]);
        n_tcp_sum = ext({8'd0, tfab_pkg::PROTO_TCP}) + ext(tfab_pkg::TCP_HDR_LEN)
                  + ext(i_item.src_ip[31:16]) + ext(i_item.src_ip[15:0])
                  + ext(i_item.dst_ip[31:16]) + ext(i_item.dst_ip[15:0])
                  + ext(i_item.src_port) + ext(i_item.dst_port)
                  + ext(i_item.seq[31:16]) + ext(i_item.seq[15:0])
                  + ext(i_item.ack[31:16]) + ext(i_item.ack[15:0])
                  + ext(tfab_pkg::TCP_OFF_FLAGS) + ext(tfab_pkg::TCP_WINDOW);
    end

    always_comb begin
        ip_fold1  = {1'b0, r_ip_sum[15:0]} + {12'd0, r_ip_sum[SW-1:16]};
        ip_fold2  = {1'b0, ip_fold1[15:0]} + {16'd0, ip_fold1[16]};
        tcp_fold1 = {1'b0, r_tcp_sum[15:0]} + {12'd0, r_tcp_sum[SW-1:16]};
        tcp_fold2 = {1'b0, tcp_fold1[15:0]} + {16'd0, tcp_fold1[16]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            o_valid    <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_item      <= i_item;
        r_ip_sum       <= n_ip_sum;
        r_tcp_sum      <= n_tcp_sum;
        o_item         <= r_s1_item;
        o_ip_checksum  <= ~ip_fold2[15:0];
        o_tcp_checksum <= ~tcp_fold2[15:0];
    end

endmodule

`default_nettype wire

[rtl/core/tfab_checker.sv]
// ----------------------------------------------------------------------------
// tfab_checker: port-level checks for the reply builder
// Checks request-to-result timing and the pass-through of copied fields.
// ----------------------------------------------------------------------------
`default_nettype none

module tfab_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_start,
    input wire logic        o_busy,
    input wire logic [31:0] i_in_ack,
    input wire logic [7:0]  i_flow_ttl,
    input wire logic        o_valid,
    input wire logic [31:0] o_out_seq,
    input wire logic [7:0]  o_out_ttl
);

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_start && !o_busy) ##1 i_rst_n ##1 i_rst_n |=> o_valid)
        else $error("accepted request produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 3))
        else $error("result without a request");

    a_seq_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_seq == $past(i_in_ack, 3)))
        else $error("reply seq differs from captured ack");

    a_ttl_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_ttl == $past(i_flow_ttl, 3)))
        else $error("reply ttl differs from flow ttl");

endmodule

bind tcp_fin_ack_reply_builder_core tfab_checker u_tfab_checker (.*);

`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the FIN+ACK reply builder core
// Sends captured IPv4/TCP header requests, first from a short directed table
// and then at random under several MAC override settings, and checks every
// strobed reply field by field, checksums included, against a local reply
// predictor or, for the typed table rows, against hand-written replies.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 232;
    localparam int NUM_SETTINGS  = 6;
    localparam int DIR_ROWS      = 11;
    localparam tfab_pkg::t_cfg_idx CFG_IDX_LAST = tfab_pkg::CFG_NEXT_HOP_MAC;

    typedef struct packed {
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] total_len;
        logic [3:0]  data_offset;
        logic [15:0] ip_id;
        logic [7:0]  ttl;
    } t_capture;

    typedef struct packed {
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] ip_id;
        logic [7:0]  ttl;
        logic [15:0] ip_csum;
        logic [15:0] tcp_csum;
    } t_fin_reply;

    typedef struct packed {
        t_capture   cap;
        logic       typed;
        t_fin_reply reply;
    } t_dir_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_start;
    logic                            o_busy;
    logic                            i_cfg_we;
    tfab_pkg::t_cfg_idx              i_cfg_idx;
    logic [tfab_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic [47:0]                     i_in_src_mac;
    logic [47:0]                     i_in_dst_mac;
    logic [31:0]                     i_in_src_ip;
    logic [31:0]                     i_in_dst_ip;
    logic [15:0]                     i_in_src_port;
    logic [15:0]                     i_in_dst_port;
    logic [31:0]                     i_in_seq;
    logic [31:0]                     i_in_ack;
    logic [15:0]                     i_in_ip_total_len;
    logic [3:0]                      i_in_tcp_data_offset;
    logic [15:0]                     i_flow_ip_id;
    logic [7:0]                      i_flow_ttl;
    logic                            o_valid;
    logic [47:0]                     o_out_src_mac;
    logic [47:0]                     o_out_dst_mac;
    logic [31:0]                     o_out_src_ip;
    logic [31:0]                     o_out_dst_ip;
    logic [15:0]                     o_out_src_port;
    logic [15:0]                     o_out_dst_port;
    logic [31:0]                     o_out_seq;
    logic [31:0]                     o_out_ack;
    logic [15:0]                     o_out_ip_id;
    logic [7:0]                      o_out_ttl;
    logic [15:0]                     o_ip_checksum;
    logic [15:0]                     o_tcp_checksum;

    logic        own_mac_on;
    logic [47:0] own_mac_addr;
    logic        next_hop_on;
    logic [47:0] next_hop_addr;

    t_fin_reply  pending_replies[$];
    t_fin_reply  seen_reply;
    int unsigned requests_sent;
    int unsigned replies_checked;
    int unsigned mismatches;
    int unsigned cycle_count;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{'{48'h0, 48'h0, 32'h0, 32'h0, 16'h0, 16'h0, 32'h0, 32'h0,
            16'h0, 4'h0, 16'h0, 8'h0}, 1'b1,
          '{48'h0, 48'h0, 32'h0, 32'h0, 16'h0, 16'h0, 32'h0, 32'hFFFF_FFEC,
            16'h1, 8'h0, 16'h7AD0, 16'hB4F6}},
        '{'{48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            16'hFFFF, 4'hF, 16'hFFFF, 8'hFF}, 1'b1,
          '{48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_FFAE,
            16'h0, 8'hFF, 16'h7BD0, 16'hB534}},
        '{'{48'h0200_0000_0001, 48'h0200_0000_0002, 32'hC0A8_0001, 32'hC0A8_0002,
            16'd443, 16'd51000, 32'h1000_0000, 32'h2000_0000,
            16'd40, 4'd5, 16'hFFFF, 8'd64}, 1'b0, '0},
        '{'{48'h0012_3456_789A, 48'h00BC_DEF0_1234, 32'h0A00_0001, 32'h0A00_0002,
            16'd80, 16'd40000, 32'h0000_0010, 32'h7FFF_FFFF,
            16'd0, 4'hF, 16'd1234, 8'd128}, 1'b0, '0},
        '{'{48'h0000_0000_0001, 48'h8000_0000_0000, 32'h0000_0001, 32'h8000_0000,
            16'd1, 16'h8000, 32'h8000_0000, 32'h0000_0001,
            16'hFFFF, 4'h0, 16'h0001, 8'd255}, 1'b0, '0},
        '{'{48'h0A0B_0C0D_0E0F, 48'h1011_1213_1415, 32'hAC10_0001, 32'hAC10_00FE,
            16'd22, 16'd60022, 32'hFFFF_FFF0, 32'hDEAD_BEEF,
            16'd1500, 4'd5, 16'h8000, 8'd32}, 1'b0, '0},
        '{'{48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
            16'hAAAA, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555,
            16'hAAAA, 4'hA, 16'hAAAA, 8'hAA}, 1'b0, '0},
        '{'{48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
            16'h5555, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA,
            16'h5555, 4'h5, 16'h5555, 8'h55}, 1'b0, '0},
        '{'{48'hFFFF_FFFF_FFFE, 48'h0000_0000_0000, 32'hFFFF_FFFE, 32'h0,
            16'h0, 16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF,
            16'd52, 4'd8, 16'h0000, 8'd1}, 1'b0, '0},
        '{'{48'h0000_FFFF_0000, 48'hFFFF_0000_FFFF, 32'h00FF_00FF, 32'hFF00_FF00,
            16'h00FF, 16'hFF00, 32'h0, 32'h0,
            16'd20, 4'd0, 16'h7FFF, 8'd128}, 1'b0, '0},
        '{'{48'h0123_4567_89AB, 48'hCDEF_0123_4567, 32'h0808_0808, 32'hC0A8_0164,
            16'd53, 16'd33333, 32'h1234_5678, 32'h9ABC_DEF0,
            16'd60, 4'd10, 16'hFFFE, 8'd0}, 1'b0, '0}
    };

    tcp_fin_ack_reply_builder_core dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_start              (i_start),
        .o_busy               (o_busy),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_in_src_mac         (i_in_src_mac),
        .i_in_dst_mac         (i_in_dst_mac),
        .i_in_src_ip          (i_in_src_ip),
        .i_in_dst_ip          (i_in_dst_ip),
        .i_in_src_port        (i_in_src_port),
        .i_in_dst_port        (i_in_dst_port),
        .i_in_seq             (i_in_seq),
        .i_in_ack             (i_in_ack),
        .i_in_ip_total_len    (i_in_ip_total_len),
        .i_in_tcp_data_offset (i_in_tcp_data_offset),
        .i_flow_ip_id         (i_flow_ip_id),
        .i_flow_ttl           (i_flow_ttl),
        .o_valid              (o_valid),
        .o_out_src_mac        (o_out_src_mac),
        .o_out_dst_mac        (o_out_dst_mac),
        .o_out_src_ip         (o_out_src_ip),
        .o_out_dst_ip         (o_out_dst_ip),
        .o_out_src_port       (o_out_src_port),
        .o_out_dst_port       (o_out_dst_port),
        .o_out_seq            (o_out_seq),
        .o_out_ack            (o_out_ack),
        .o_out_ip_id          (o_out_ip_id),
        .o_out_ttl            (o_out_ttl),
        .o_ip_checksum        (o_ip_checksum),
        .o_tcp_checksum       (o_tcp_checksum)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [31:0] add_halves(input logic [31:0] acc,
                                               input logic [31:0] word);
        return acc + {16'h0, word[31:16]} + {16'h0, word[15:0]};
    endfunction

    function automatic logic [15:0] fold_complement(input logic [31:0] acc);
        logic [31:0] s;
        s = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
        s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
        return ~s[15:0];
    endfunction

    function automatic t_fin_reply predict_reply(input t_capture c);
        t_fin_reply  r;
        logic [31:0] sum;
        r.src_mac  = own_mac_on ? own_mac_addr : c.dst_mac;
        r.dst_mac  = next_hop_on ? next_hop_addr : c.src_mac;
        r.src_ip   = c.dst_ip;
        r.dst_ip   = c.src_ip;
        r.src_port = c.dst_port;
        r.dst_port = c.src_port;
        r.seq      = c.ack;
        r.ack      = c.seq + {16'h0, c.total_len} - {26'h0, c.data_offset, 2'b00}
                     - tfab_pkg::IP_TCP_MIN_HDR;
        r.ip_id    = c.ip_id + 16'd1;
        r.ttl      = c.ttl;

        sum = {16'h0, tfab_pkg::IP_VER_IHL_TOS} + {16'h0, tfab_pkg::IP_TOTAL_LEN}
              + {16'h0, r.ip_id} + {16'h0, tfab_pkg::IP_FLAG_DF}
              + {16'h0, r.ttl, tfab_pkg::PROTO_TCP};
        sum = add_halves(sum, r.src_ip);
        sum = add_halves(sum, r.dst_ip);
        r.ip_csum = fold_complement(sum);

        sum = {24'h0, tfab_pkg::PROTO_TCP} + {16'h0, tfab_pkg::TCP_HDR_LEN};
        sum = add_halves(sum, r.src_ip);
        sum = add_halves(sum, r.dst_ip);
        sum = sum + {16'h0, r.src_port} + {16'h0, r.dst_port};
        sum = add_halves(sum, r.seq);
        sum = add_halves(sum, r.ack);
        sum = sum + {16'h0, tfab_pkg::TCP_OFF_FLAGS} + {16'h0, tfab_pkg::TCP_WINDOW};
        r.tcp_csum = fold_complement(sum);
        return r;
    endfunction

    function automatic logic [47:0] rand_bits(input int unsigned width);
        logic [63:0] raw;
        logic [47:0] mask;
        raw  = {$urandom, $urandom};
        mask = (48'd1 << width) - 48'd1;
        case ($urandom_range(0, 15))
            0: raw = '0;
            1: raw = '1;
            default: ;
        endcase
        return raw[47:0] & mask;
    endfunction

    task automatic write_cfg(input tfab_pkg::t_cfg_idx idx,
                             input logic [tfab_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            tfab_pkg::CFG_OWN_MAC_EN:      own_mac_on    = data[0];
            tfab_pkg::CFG_OWN_MAC:         own_mac_addr  = data[47:0];
            tfab_pkg::CFG_NEXT_HOP_MAC_EN: next_hop_on   = data[0];
            tfab_pkg::CFG_NEXT_HOP_MAC:    next_hop_addr = data[47:0];
            default: ;
        endcase
    endtask

    task automatic send_capture(input t_capture c, input int unsigned idle_pct,
                                input t_fin_reply want);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_in_src_mac         <= c.src_mac;
        i_in_dst_mac         <= c.dst_mac;
        i_in_src_ip          <= c.src_ip;
        i_in_dst_ip          <= c.dst_ip;
        i_in_src_port        <= c.src_port;
        i_in_dst_port        <= c.dst_port;
        i_in_seq             <= c.seq;
        i_in_ack             <= c.ack;
        i_in_ip_total_len    <= c.total_len;
        i_in_tcp_data_offset <= c.data_offset;
        i_flow_ip_id         <= c.ip_id;
        i_flow_ttl           <= c.ttl;
        i_start              <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        pending_replies.push_back(want);
        requests_sent++;
    endtask

    task automatic drain_replies();
        i_start <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [47:0] want,
                               input logic [47:0] seen);
        if (want !== seen) begin
            $display("%0t ns: reply %0d %s expected %h actual %h",
                     $time, replies_checked, name, want, seen);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL tcp_fin_ack_reply_builder_core");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            seen_reply = '{o_out_src_mac, o_out_dst_mac, o_out_src_ip, o_out_dst_ip,
                           o_out_src_port, o_out_dst_port, o_out_seq, o_out_ack,
                           o_out_ip_id, o_out_ttl, o_ip_checksum, o_tcp_checksum};
            if (pending_replies.size() == 0) begin
                $display("%0t ns: reply with none pending, expected nothing actual %h",
                         $time, seen_reply);
                mismatches++;
            end else begin
                t_fin_reply want;
                want = pending_replies.pop_front();
                check_field("src_mac", want.src_mac, seen_reply.src_mac);
                check_field("dst_mac", want.dst_mac, seen_reply.dst_mac);
                check_field("src_ip", 48'(want.src_ip), 48'(seen_reply.src_ip));
                check_field("dst_ip", 48'(want.dst_ip), 48'(seen_reply.dst_ip));
                check_field("src_port", 48'(want.src_port), 48'(seen_reply.src_port));
                check_field("dst_port", 48'(want.dst_port), 48'(seen_reply.dst_port));
                check_field("seq", 48'(want.seq), 48'(seen_reply.seq));
                check_field("ack", 48'(want.ack), 48'(seen_reply.ack));
                check_field("ip_id", 48'(want.ip_id), 48'(seen_reply.ip_id));
                check_field("ttl", 48'(want.ttl), 48'(seen_reply.ttl));
                check_field("ip_checksum", 48'(want.ip_csum), 48'(seen_reply.ip_csum));
                check_field("tcp_checksum", 48'(want.tcp_csum), 48'(seen_reply.tcp_csum));
                replies_checked++;
            end
        end
    end

    initial begin
        t_capture    cap;
        int unsigned idle_pct;
        logic        set_own_on;
        logic [47:0] set_own_mac;
        logic        set_nh_on;
        logic [47:0] set_nh_mac;

        requests_sent   = 0;
        replies_checked = 0;
        mismatches      = 0;
        cycle_count     = 0;
        own_mac_on      = 1'b0;
        own_mac_addr    = '0;
        next_hop_on     = 1'b0;
        next_hop_addr   = '0;

        i_rst_n              <= 1'b0;
        i_start              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= tfab_pkg::CFG_OWN_MAC_EN;
        i_cfg_data           <= '0;
        i_in_src_mac         <= '0;
        i_in_dst_mac         <= '0;
        i_in_src_ip          <= '0;
        i_in_dst_ip          <= '0;
        i_in_src_port        <= '0;
        i_in_dst_port        <= '0;
        i_in_seq             <= '0;
        i_in_ack             <= '0;
        i_in_ip_total_len    <= '0;
        i_in_tcp_data_offset <= '0;
        i_flow_ip_id         <= '0;
        i_flow_ttl           <= '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            send_capture(dir_rows[k].cap, 0,
                         dir_rows[k].typed ? dir_rows[k].reply
                                           : predict_reply(dir_rows[k].cap));
        end

        for (int phase = 0; phase < NUM_SETTINGS; phase++) begin
            drain_replies();
            set_own_mac = rand_bits(48);
            set_nh_mac  = rand_bits(48);
            case (phase)
                0: begin
                    set_own_on  = 1'b1;
                    set_own_mac = '1;
                    set_nh_on   = 1'b0;
                    set_nh_mac  = '0;
                end
                1: begin
                    set_own_on = 1'b0;
                    set_nh_on  = 1'b1;
                    set_nh_mac = '0;
                end
                2: begin
                    set_own_on  = 1'b1;
                    set_own_mac = '0;
                    set_nh_on   = 1'b1;
                    set_nh_mac  = '1;
                end
                3: begin
                    set_own_on = 1'b1;
                    set_nh_on  = 1'b1;
                end
                4: begin
                    set_own_on = 1'b0;
                    set_nh_on  = 1'b0;
                end
                default: begin
                    set_own_on = 1'($urandom_range(0, 1));
                    set_nh_on  = 1'($urandom_range(0, 1));
                end
            endcase
            write_cfg(tfab_pkg::CFG_OWN_MAC_EN, {47'(rand_bits(47)), set_own_on});
            write_cfg(tfab_pkg::CFG_OWN_MAC, set_own_mac);
            write_cfg(tfab_pkg::CFG_NEXT_HOP_MAC_EN, {47'(rand_bits(47)), set_nh_on});
            write_cfg(tfab_pkg::CFG_NEXT_HOP_MAC, set_nh_mac);
            // unmapped index: drop the write
            write_cfg(tfab_pkg::t_cfg_idx'(CFG_IDX_LAST + 1 + $urandom_range(0, 3)),
                      rand_bits(48));
            i_cfg_we <= 1'b0;

            idle_pct = (phase < 2) ? 23 : ((phase < 4) ? 46 : 0);
            repeat (PHASE_ITEMS) begin
                cap.src_mac     = rand_bits(48);
                cap.dst_mac     = rand_bits(48);
                cap.src_ip      = 32'(rand_bits(32));
                cap.dst_ip      = 32'(rand_bits(32));
                cap.src_port    = 16'(rand_bits(16));
                cap.dst_port    = 16'(rand_bits(16));
                cap.seq         = 32'(rand_bits(32));
                cap.ack         = 32'(rand_bits(32));
                cap.total_len   = 16'(rand_bits(16));
                cap.data_offset = 4'(rand_bits(4));
                cap.ip_id       = 16'(rand_bits(16));
                cap.ttl         = 8'(rand_bits(8));
                // mostly well-formed lengths
                if ($urandom_range(0, 3) != 0) begin
                    cap.data_offset = 4'($urandom_range(5, 15));
                    cap.total_len   = 16'(20 + 4 * cap.data_offset + $urandom_range(0, 1460));
                end
                send_capture(cap, idle_pct, predict_reply(cap));
            end
        end
        drain_replies();

        $display("Sent %0d capture requests (%0d directed) under %0d MAC override settings.",
                 requests_sent, DIR_ROWS, NUM_SETTINGS + 1);
        $display("Checked %0d FIN+ACK replies field by field; %0d mismatches.",
                 replies_checked, mismatches);
        if (mismatches == 0 && pending_replies.size() == 0) begin
            $display("PASS tcp_fin_ack_reply_builder_core");
        end else begin
            $display("FAIL tcp_fin_ack_reply_builder_core");
        end
        $finish;
    end

endmodule

[tcp_fin_ack_reply_builder_core.f]
rtl/core/tfab_pkg.sv
rtl/core/tfab_front.sv
rtl/core/tfab_queue.sv
rtl/core/tfab_back.sv
rtl/core/tcp_fin_ack_reply_builder_core.sv
rtl/core/tfab_checker.sv
sim/tb_top.sv
